/* design/sactm_pkg.sv */
package sactm_pkg;

  localparam int unsigned TAG_W     = 64;
  localparam int unsigned CNT_W     = 64;
  localparam int unsigned MAX_BYTES = 64;

  // counter slots: {is_store, miss}
  localparam logic [1:0] SLOT_LOAD_HIT   = 2'd0;
  localparam logic [1:0] SLOT_LOAD_MISS  = 2'd1;
  localparam logic [1:0] SLOT_STORE_HIT  = 2'd2;
  localparam logic [1:0] SLOT_STORE_MISS = 2'd3;

  typedef struct packed {
    logic bump;
    logic is_store;
    logic miss;
  } bump_req_t;

  typedef logic [3:0][CNT_W-1:0] cnt_bank_t;

endpackage

/* design/sactm_ram.sv */
module sactm_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/sactm_counters.sv */
module sactm_counters
  import sactm_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  bump_req_t bump_i,
  output cnt_bank_t cnt_o
);

  cnt_bank_t        cnt_q;
  logic [1:0]       slot;
  logic [CNT_W-1:0] inc_d;

  // one shared incrementer for the whole bank
  always_comb begin
    case ({bump_i.is_store, bump_i.miss})
      2'b00:   slot = SLOT_LOAD_HIT;
      2'b01:   slot = SLOT_LOAD_MISS;
      2'b10:   slot = SLOT_STORE_HIT;
      default: slot = SLOT_STORE_MISS;
    endcase
    inc_d = cnt_q[slot] + CNT_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (bump_i.bump) begin
      cnt_q[slot] <= inc_d;
    end
  end

  assign cnt_o = cnt_q;

endmodule

/* design/set_assoc_cache_tag_model_core.sv */
// Tag-only set-associative cache model with round-robin replacement.
// Input channel s_axis: one beat per load or store (tuser = opcode, tdata = address
// and byte count). Output channel m_axis: one beat per input with the hit flag, the
// number of lines touched and the four hit/miss counters after this access.
// Config port: cfg_we_i/cfg_addr_i/cfg_data_i write one register per cycle, no
// read-back; indexes 0..3 are line size log2, set count log2, ways in use and
// store allocate, other indexes are ignored.
// Per access: for every touched line a row read, then the ways in use are compared
// one at a time on the single tag comparator (the search stops on a hit).
// After the last compare the access passes S_DONE, where the counters are bumped,
// and S_OUT, which loads the result into the output register.
// After reset the tag rows and victim pointers are swept over all NUM_SETS sets,
// one set a cycle, with s_axis_tready low. A write of ways in use starts the same
// sweep over the pointers only, tags are kept.
// The result sits in an output register; the next access is taken while it waits.
// A stalled receiver only holds the block when a second result is ready to leave.
module set_assoc_cache_tag_model_core
  import sactm_pkg::*;
#(
  parameter int unsigned NUM_SETS       = 1024,
  parameter int unsigned MAX_WAYS       = 16,
  parameter int unsigned MAX_SPAN_LINES = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [7:0]   cfg_addr_i,
  input  logic [4:0]   cfg_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [71:0]  s_axis_tdata,   // address[63:0], byte_count[70:64], pad
  input  logic [0:0]   s_axis_tuser,   // opcode
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [263:0] m_axis_tdata    // all_hit, lines_touched, load_hit_count,
                                       // load_miss_count, store_hit_count,
                                       // store_miss_count
);

  localparam int unsigned SET_AW   = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int unsigned SET_LMAX = $clog2(NUM_SETS + 1) - 1;
  localparam int unsigned WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int unsigned WCNT_W   = $clog2(MAX_WAYS + 1);
  localparam int unsigned ROW_W    = MAX_WAYS * TAG_W;

  localparam logic [7:0] REG_LINE_LOG2 = 8'd0;
  localparam logic [7:0] REG_SET_LOG2  = 8'd1;
  localparam logic [7:0] REG_WAYS      = 8'd2;
  localparam logic [7:0] REG_ST_ALLOC  = 8'd3;

  localparam logic [2:0] S_INIT = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_READ = 3'd2;
  localparam logic [2:0] S_CMP  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]        state_q;
  logic              clr_q;
  logic [SET_AW-1:0] init_cnt_q;
  logic [3:0]        line_log2_q;
  logic [3:0]        set_log2_q;
  logic [4:0]        ways_q;
  logic              st_alloc_q;
  logic [WAY_W-1:0]  way_q;
  logic [6:0]        rem_q;
  logic [6:0]        lines_q;
  logic              all_hit_q;
  logic              out_valid_q;
  logic              op_q;
  logic [63:0]       addr_q;
  logic [TAG_W-1:0]  tag_q;
  logic [SET_AW-1:0] set_q;
  logic [263:0]      out_data_q;

  logic [31:0]       ways_ext;
  logic [WCNT_W-1:0] eff_ways;
  logic [WAY_W-1:0]  last_way;
  logic [63:0]       lmask;
  logic [63:0]       line_bytes;
  logic [TAG_W-1:0]  tag_now;
  logic [3:0]        set_log2_eff;
  logic [SET_AW-1:0] set_mask;
  logic [SET_AW-1:0] set_idx;
  logic [6:0]        size_eff;
  logic [16:0]       span;
  logic [17:0]       span_lines;
  logic [31:0]       lines_raw;
  logic [6:0]        lines_in;
  logic              in_acc;
  logic              allocate;
  logic              ways_wr;

  logic                             tag_we;
  logic [SET_AW-1:0]                tag_waddr;
  logic [ROW_W-1:0]                 tag_wdata;
  logic                             rd_en;
  logic [ROW_W-1:0]                 tag_rdata;
  logic                             ptr_we;
  logic [WAY_W-1:0]                 ptr_wdata;
  logic [WAY_W-1:0]                 ptr_rdata;
  logic [MAX_WAYS-1:0][TAG_W-1:0]   row_rd;
  logic [MAX_WAYS-1:0][TAG_W-1:0]   row_new;
  logic [WAY_W-1:0]                 ptr_cl;
  logic [WAY_W-1:0]                 ptr_new;
  logic                             hit_way;
  logic                             way_last;
  logic                             out_free;
  bump_req_t                        bump;
  cnt_bank_t                        cnt;

  // geometry
  always_comb begin
    ways_ext = 32'(ways_q);
    if (ways_ext == 32'd0) begin
      ways_ext = 32'd1;
    end
    if (ways_ext > MAX_WAYS) begin
      ways_ext = MAX_WAYS;
    end
    eff_ways     = WCNT_W'(ways_ext);
    last_way     = WAY_W'(ways_ext - 32'd1);
    lmask        = ~(64'hFFFF_FFFF_FFFF_FFFF << line_log2_q);
    line_bytes   = 64'd1 << line_log2_q;
    tag_now      = addr_q >> line_log2_q;
    set_log2_eff = (32'(set_log2_q) > SET_LMAX) ? 4'(SET_LMAX) : set_log2_q;
    set_mask     = SET_AW'(((SET_AW + 1)'(1) << set_log2_eff) - (SET_AW + 1)'(1));
    set_idx      = tag_now[SET_AW-1:0] & set_mask;
  end

  // span of the incoming access
  always_comb begin
    size_eff   = (32'(s_axis_tdata[70:64]) > MAX_BYTES) ? 7'(MAX_BYTES)
                                                        : s_axis_tdata[70:64];
    span       = 17'(s_axis_tdata[15:0] & lmask[15:0]) + 17'(size_eff) - 17'd1;
    span_lines = 18'(span >> line_log2_q) + 18'd1;
    lines_raw  = (size_eff <= 7'd1) ? 32'd1 : 32'(span_lines);
    lines_in   = (lines_raw > MAX_SPAN_LINES) ? 7'(MAX_SPAN_LINES) : 7'(lines_raw);
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign allocate      = !op_q || st_alloc_q;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign ways_wr       = cfg_we_i && (cfg_addr_i == REG_WAYS);

  // shared tag comparator, one way a cycle
  always_comb begin
    row_rd   = tag_rdata;
    hit_way  = (row_rd[way_q] == tag_q);
    way_last = (way_q == last_way);
    ptr_cl   = (32'(ptr_rdata) >= 32'(eff_ways)) ? last_way : ptr_rdata;
    ptr_new  = (ptr_cl == '0) ? last_way : ptr_cl - WAY_W'(1);
    row_new  = row_rd;
    row_new[ptr_cl] = tag_q;
  end

  always_comb begin
    rd_en     = (state_q == S_READ);
    tag_we    = 1'b0;
    tag_waddr = set_q;
    tag_wdata = row_new;
    ptr_we    = 1'b0;
    ptr_wdata = ptr_new;
    if (state_q == S_INIT) begin
      tag_we    = clr_q;
      tag_waddr = init_cnt_q;
      tag_wdata = '0;
      ptr_we    = 1'b1;
      ptr_wdata = last_way;
    end else if (state_q == S_CMP && !hit_way && way_last && allocate) begin
      tag_we = 1'b1;
      ptr_we = 1'b1;
    end
    bump.bump     = (state_q == S_DONE);
    bump.is_store = op_q;
    bump.miss     = !all_hit_q;
  end

  sactm_ram #(
    .WIDTH(ROW_W),
    .DEPTH(NUM_SETS)
  ) u_tag_ram (
    .clk_i  (clk_i),
    .we_i   (tag_we),
    .waddr_i(tag_waddr),
    .wdata_i(tag_wdata),
    .re_i   (rd_en),
    .raddr_i(set_idx),
    .rdata_o(tag_rdata)
  );

  sactm_ram #(
    .WIDTH(WAY_W),
    .DEPTH(NUM_SETS)
  ) u_ptr_ram (
    .clk_i  (clk_i),
    .we_i   (ptr_we),
    .waddr_i(state_q == S_INIT ? init_cnt_q : set_q),
    .wdata_i(ptr_wdata),
    .re_i   (rd_en),
    .raddr_i(set_idx),
    .rdata_o(ptr_rdata)
  );

  sactm_counters u_counters (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .bump_i(bump),
    .cnt_o (cnt)
  );

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      clr_q       <= 1'b1;
      init_cnt_q  <= '0;
      line_log2_q <= 4'd6;
      set_log2_q  <= 4'd5;
      ways_q      <= 5'd8;
      st_alloc_q  <= 1'b1;
      way_q       <= '0;
      rem_q       <= '0;
      lines_q     <= '0;
      all_hit_q   <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == S_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (ways_wr) begin
        init_cnt_q <= '0;
        state_q    <= S_INIT;
      end else begin
        case (state_q)
          S_INIT: begin
            init_cnt_q <= init_cnt_q + SET_AW'(1);
            if (init_cnt_q == SET_AW'(NUM_SETS - 1)) begin
              clr_q   <= 1'b0;
              state_q <= S_IDLE;
            end
          end
          S_IDLE: begin
            if (in_acc) begin
              rem_q     <= lines_in;
              lines_q   <= lines_in;
              all_hit_q <= 1'b1;
              state_q   <= S_READ;
            end
          end
          S_READ: begin
            way_q   <= '0;
            state_q <= S_CMP;
          end
          S_CMP: begin
            if (hit_way || way_last) begin
              if (!hit_way) begin
                all_hit_q <= 1'b0;
              end
              rem_q   <= rem_q - 7'd1;
              state_q <= (rem_q == 7'd1) ? S_DONE : S_READ;
            end else begin
              way_q <= way_q + WAY_W'(1);
            end
          end
          S_DONE: begin
            state_q <= S_OUT;
          end
          S_OUT: begin
            if (out_free) begin
              state_q <= S_IDLE;
            end
          end
          default: begin
            state_q <= S_IDLE;
          end
        endcase
      end
      if (cfg_we_i) begin
        case (cfg_addr_i)
          REG_LINE_LOG2: line_log2_q <= cfg_data_i[3:0];
          REG_SET_LOG2:  set_log2_q  <= cfg_data_i[3:0];
          REG_WAYS:      ways_q      <= cfg_data_i;
          REG_ST_ALLOC:  st_alloc_q  <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q   <= s_axis_tuser[0];
      addr_q <= s_axis_tdata[63:0];
    end
    if (state_q == S_READ) begin
      tag_q <= tag_now;
      set_q <= set_idx;
    end
    if (state_q == S_CMP && (hit_way || way_last)) begin
      addr_q <= (addr_q & ~lmask) + line_bytes;
    end
    if (state_q == S_OUT && out_free) begin
      out_data_q <= {cnt[3], cnt[2], cnt[1], cnt[0], lines_q, all_hit_q};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  a_way_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CMP |-> 32'(way_q) <= 32'(last_way))
    else $error("way search ran past the last way in use");

  a_rem_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ || state_q == S_CMP) |-> (rem_q != 7'd0 && rem_q <= lines_q))
    else $error("line walk count out of range");

  a_alloc_after_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tag_we && state_q != S_INIT) |-> (!hit_way && way_last))
    else $error("tag row written before the search missed on every way");

  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && out_free && !cfg_we_i) |=> (out_valid_q && state_q == S_IDLE))
    else $error("finished access did not reach the output register");

endmodule
